### src/jcbb_pkg.sv
// Shared types, constants and the magnitude decode for the JPEG coefficient
// block builder. No dependencies; used by every module in src.
`timescale 1ns / 1ps

package jcbb_pkg;

  localparam int NUM_COMPONENTS = 4;
  localparam int PRED_IDX_W     = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int BLOCK_SIZE     = 64;
  localparam int POS_W          = 6;
  localparam int ZCNT_W         = 7;
  localparam int COEF_W         = 16;
  localparam int MAX_CLASS      = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;

  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(BLOCK_SIZE - 1);
  localparam logic [ZCNT_W-1:0] BLOCK_LEN  = ZCNT_W'(BLOCK_SIZE);
  localparam logic [3:0]        NIBBLE     = 4'hF;

  typedef enum logic {
    CMD_DC = 1'b0,
    CMD_AC = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [1:0]  component;
    logic [7:0]  symbol;
    logic [15:0] extra_bits;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         position;
    logic signed [15:0] coefficient;
    logic               last_in_block;
    logic               error;
  } out_item_t;

  // One unit of back-end work: zero_cnt zeros from start_pos, then
  // optionally one value; error tags the final result of the job.
  typedef struct packed {
    logic [POS_W-1:0]  start_pos;
    logic [ZCNT_W-1:0] zero_cnt;
    logic              has_value;
    logic [COEF_W-1:0] value;
    logic              error;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Magnitude-class decode: class m, index i = extra & (2^m-1).
  // Negative half is i - (2^m - 1), i.e. i minus the mask.
  function automatic logic [COEF_W-1:0] mag_value(logic [4:0] m, logic [15:0] extra);
    logic [16:0] mask;
    logic [16:0] idx;
    logic [16:0] diff;
    logic        upper;
    mask  = (17'd1 << m) - 17'd1;
    idx   = {1'b0, extra} & mask;
    upper = (idx & (mask ^ (mask >> 1))) != 17'd0;
    diff  = idx - mask;
    if (m == 5'd0) begin
      return '0;
    end else if (upper) begin
      return idx[COEF_W-1:0];
    end else begin
      return diff[COEF_W-1:0];
    end
  endfunction

endpackage

### src/jcbb_front.sv
// Front end: accepts input beats, tracks block position and DC predictors,
// and makes each DC or in-block AC beat one back-end job. Uses jcbb_pkg.
`timescale 1ns / 1ps

module jcbb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jcbb_pkg::in_item_t in_item_i,
  input  jcbb_pkg::q_status_t q_status_i,
  output logic               push_o,
  output jcbb_pkg::job_t     job_o
);

  logic [jcbb_pkg::COEF_W-1:0] pred_q [jcbb_pkg::NUM_COMPONENTS];
  logic [jcbb_pkg::COEF_W-1:0] pred_d;
  logic                        pred_we;
  logic [jcbb_pkg::POS_W-1:0]  next_pos_q, next_pos_d;
  logic                        in_block_q, in_block_d;

  logic                           accept;
  logic [1:0]                     comp_c;
  logic [jcbb_pkg::PRED_IDX_W-1:0] pred_sel;
  logic [4:0]                     dc_class;
  logic [3:0]                     run, size;
  logic [jcbb_pkg::ZCNT_W-1:0]    end_pos;
  logic [jcbb_pkg::ZCNT_W-1:0]    to_end;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    comp_c = in_item_i.component;
    if ({1'b0, comp_c} >= 3'(jcbb_pkg::NUM_COMPONENTS)) begin
      comp_c = 2'(jcbb_pkg::NUM_COMPONENTS - 1);
    end
    pred_sel = jcbb_pkg::PRED_IDX_W'(comp_c);
    dc_class = (in_item_i.symbol > 8'(jcbb_pkg::MAX_CLASS)) ?
               5'(jcbb_pkg::MAX_CLASS) : in_item_i.symbol[4:0];
    run      = in_item_i.symbol[7:4] & jcbb_pkg::NIBBLE;
    size     = in_item_i.symbol[3:0] & jcbb_pkg::NIBBLE;
    end_pos  = {1'b0, next_pos_q} + {3'b000, run};
    to_end   = jcbb_pkg::BLOCK_LEN - {1'b0, next_pos_q};
  end

  always_comb begin
    push_o     = 1'b0;
    job_o      = '0;
    pred_we    = 1'b0;
    pred_d     = jcbb_pkg::mag_value(dc_class, in_item_i.extra_bits) + pred_q[pred_sel];
    next_pos_d = next_pos_q;
    in_block_d = in_block_q;
    if (accept) begin
      if (in_item_i.command == jcbb_pkg::CMD_DC) begin
        push_o          = 1'b1;
        job_o.start_pos = '0;
        job_o.zero_cnt  = '0;
        job_o.has_value = 1'b1;
        job_o.value     = pred_d;
        job_o.error     = in_block_q;
        pred_we         = 1'b1;
        next_pos_d      = jcbb_pkg::POS_W'(1);
        in_block_d      = 1'b1;
      end else if (in_block_q) begin
        push_o          = 1'b1;
        job_o.start_pos = next_pos_q;
        if (run == 4'd0 && size == 4'd0) begin
          // end of block: zero-fill through the last position
          job_o.zero_cnt  = to_end;
          next_pos_d      = '0;
          in_block_d      = 1'b0;
        end else if (end_pos > {1'b0, jcbb_pkg::LAST_POS}) begin
          // run overruns the block: zeros to the end, value dropped
          job_o.zero_cnt  = to_end;
          job_o.error     = 1'b1;
          next_pos_d      = '0;
          in_block_d      = 1'b0;
        end else begin
          job_o.zero_cnt  = {3'b000, run};
          job_o.has_value = 1'b1;
          job_o.value     = jcbb_pkg::mag_value({1'b0, size}, in_item_i.extra_bits);
          if (end_pos[jcbb_pkg::POS_W-1:0] == jcbb_pkg::LAST_POS) begin
            next_pos_d = '0;
            in_block_d = 1'b0;
          end else begin
            next_pos_d = end_pos[jcbb_pkg::POS_W-1:0] + jcbb_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_pos_q <= '0;
      in_block_q <= 1'b0;
      for (int c = 0; c < jcbb_pkg::NUM_COMPONENTS; c++) begin
        pred_q[c] <= '0;
      end
    end else begin
      next_pos_q <= next_pos_d;
      in_block_q <= in_block_d;
      if (pred_we) begin
        pred_q[pred_sel] <= pred_d;
      end
    end
  end

endmodule

### src/jcbb_job_queue.sv
// Short job queue between front and back ends, held in flops.
// Uses jcbb_pkg for the job type and depth.
`timescale 1ns / 1ps

module jcbb_job_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jcbb_pkg::job_t      job_i,
  input  logic                pop_i,
  output jcbb_pkg::job_t      job_o,
  output jcbb_pkg::q_status_t status_o
);

  jcbb_pkg::job_t              mem_q [jcbb_pkg::QUEUE_DEPTH];
  logic [jcbb_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [jcbb_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign status_o.full  = (cnt_q == jcbb_pkg::QCNT_W'(jcbb_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + jcbb_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - jcbb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + jcbb_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + jcbb_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

### src/jcbb_back.sv
// Back end: sequences one job into coefficient beats, one per
// cycle unless out_stall_i holds the output register. Uses jcbb_pkg.
`timescale 1ns / 1ps

module jcbb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jcbb_pkg::job_t      job_i,
  input  jcbb_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jcbb_pkg::out_item_t out_item_o
);

  logic                        busy_q, busy_d;
  logic [jcbb_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [jcbb_pkg::ZCNT_W-1:0] nz_q, nz_d;
  logic                        hv_q;
  logic [jcbb_pkg::COEF_W-1:0] val_q;
  logic                        err_q;
  logic                        out_valid_q, out_valid_d;
  jcbb_pkg::out_item_t         out_item_q, out_item_d;

  logic slot_free, emit, emit_zero, final_beat;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pop_o      = !busy_q && !q_status_i.empty;
  assign emit       = busy_q && slot_free;
  assign emit_zero  = (nz_q != '0);
  assign final_beat = emit_zero ? (nz_q == jcbb_pkg::ZCNT_W'(1) && !hv_q) : 1'b1;

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    nz_d        = nz_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d              = 1'b1;
      out_item_d.position      = pos_q;
      out_item_d.coefficient   = emit_zero ? '0 : $signed(val_q);
      out_item_d.last_in_block = (pos_q == jcbb_pkg::LAST_POS);
      out_item_d.error         = final_beat && err_q;
      pos_d                    = pos_q + jcbb_pkg::POS_W'(1);
      if (emit_zero) begin
        nz_d = nz_q - jcbb_pkg::ZCNT_W'(1);
      end
      busy_d = !final_beat;
    end else if (pop_o) begin
      busy_d = 1'b1;
      pos_d  = job_i.start_pos;
      nz_d   = job_i.zero_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    nz_q       <= nz_d;
    out_item_q <= out_item_d;
    if (pop_o) begin
      hv_q  <= job_i.has_value;
      val_q <= job_i.value;
      err_q <= job_i.error;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### src/jpeg_coefficient_block_builder_unit.sv
// Channel   Direction  Handshake              Beat
// in        input      in_valid_i/in_stall_o  in_item_t: command, component, symbol, extra_bits
// out       output     out_valid_o/out_stall_i out_item_t: position, coefficient, last, error
//
// A DC beat yields one result; an AC beat yields run+1 results (fewer on overrun);
// EOB yields 64 minus the open position; an AC beat with no open block yields none.
// The back-end sequencer emits one result per cycle unless out_stall_i holds it, and loads
// each job while idle; the two-entry job queue lets the front take new beats meanwhile.
// Reset (rst_ni, async low) clears predictors, block state, queue and output valid.
// Output results wait in a register while out_stall_i is high.
// Top level: instantiates jcbb_front, jcbb_job_queue and jcbb_back; uses jcbb_pkg.
`timescale 1ns / 1ps

module jpeg_coefficient_block_builder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jcbb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jcbb_pkg::out_item_t out_item_o
);

  jcbb_pkg::q_status_t q_status;
  jcbb_pkg::job_t      push_job, head_job;
  logic                push, pop;

  jcbb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  jcbb_job_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  jcbb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // position expected after the last delivered beat, for the checks below
  logic [jcbb_pkg::POS_W-1:0] exp_pos_q;
  logic                       out_fire;

  assign out_fire = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (out_fire) begin
      exp_pos_q <= out_item_o.position + jcbb_pkg::POS_W'(1);
    end
  end

  a_pos_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (out_item_o.position == '0 || out_item_o.position == exp_pos_q))
    else $error("coefficient position skipped or repeated");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.last_in_block == (out_item_o.position == jcbb_pkg::LAST_POS)))
    else $error("last_in_block does not match position");

  a_error_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error) |->
      (out_item_o.position == '0 || out_item_o.position == jcbb_pkg::LAST_POS))
    else $error("error flag on an unexpected position");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !push)
    else $error("job pushed into a full queue");

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for jpeg_coefficient_block_builder_unit.
// Predicts every emitted coefficient beat from the symbol beats; needs jcbb_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [7:0] SYM_EOB = 8'h00;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         IN_W = $bits(jcbb_pkg::in_item_t);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  jcbb_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  jcbb_pkg::out_item_t out_item_o;

  jpeg_coefficient_block_builder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // predictor state
  logic [15:0]         dc_pred [jcbb_pkg::NUM_COMPONENTS];
  int unsigned         next_pos;
  bit                  blk_open;
  jcbb_pkg::out_item_t coef_q [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  int fail_cnt;
  int sym_cnt;
  int coef_cnt;
  int blk_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // output side: random stalls, plus a long hold when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // checker: every accepted coefficient beat against the oldest prediction
  initial begin
    jcbb_pkg::out_item_t exp_c;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        coef_cnt++;
        if (out_item_o.last_in_block) blk_cnt++;
        if (coef_q.size() == 0) begin
          $error("unexpected coefficient beat: position %0d value %0d",
                 out_item_o.position, out_item_o.coefficient);
          fail_cnt++;
        end else begin
          exp_c = coef_q.pop_front();
          if (out_item_o.position !== exp_c.position) begin
            $error("position: expected %0d, got %0d", exp_c.position, out_item_o.position);
            fail_cnt++;
          end
          if (out_item_o.coefficient !== exp_c.coefficient) begin
            $error("coefficient: expected %0d, got %0d",
                   exp_c.coefficient, out_item_o.coefficient);
            fail_cnt++;
          end
          if (out_item_o.last_in_block !== exp_c.last_in_block) begin
            $error("last_in_block: expected %0b, got %0b",
                   exp_c.last_in_block, out_item_o.last_in_block);
            fail_cnt++;
          end
          if (out_item_o.error !== exp_c.error) begin
            $error("error: expected %0b, got %0b", exp_c.error, out_item_o.error);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic logic [15:0] decode_magnitude(int unsigned m, logic [15:0] extra);
    int unsigned idx;
    int unsigned half;
    if (m == 0) return 16'd0;
    if (m > 16) m = 16;
    idx  = extra & ((32'd1 << m) - 32'd1);
    half = 32'd1 << (m - 1);
    if (idx >= half) return idx[15:0];
    return 16'(idx + 32'd1 - (32'd1 << m));
  endfunction

  task automatic push_coef(int unsigned pos, logic [15:0] val, bit last, bit err);
    jcbb_pkg::out_item_t c;
    c.position      = pos[5:0];
    c.coefficient   = val;
    c.last_in_block = last;
    c.error         = err;
    coef_q.push_back(c);
  endtask

  task automatic predict_coefs(input jcbb_pkg::in_item_t it);
    int unsigned comp;
    int unsigned run;
    int unsigned size;
    int unsigned p;
    int unsigned z;
    bit          overrun;
    logic [15:0] val;
    if (it.command == jcbb_pkg::CMD_DC) begin
      comp = it.component;
      if (comp >= jcbb_pkg::NUM_COMPONENTS) comp = jcbb_pkg::NUM_COMPONENTS - 1;
      dc_pred[comp] = decode_magnitude(it.symbol, it.extra_bits) + dc_pred[comp];
      push_coef(0, dc_pred[comp], 1'b0, blk_open);
      next_pos = 1;
      blk_open = 1'b1;
    end else if (blk_open) begin
      run  = it.symbol[7:4];
      size = it.symbol[3:0];
      p    = next_pos;
      if (run == 0 && size == 0) begin
        // end of block: zero-fill to the last position
        while (p <= jcbb_pkg::LAST_POS) begin
          push_coef(p, 16'd0, p == jcbb_pkg::LAST_POS, 1'b0);
          p++;
        end
        next_pos = 0;
        blk_open = 1'b0;
      end else begin
        val     = decode_magnitude(size, it.extra_bits);
        overrun = 1'b0;
        for (z = 0; z < run && !overrun; z++) begin
          if (p == jcbb_pkg::LAST_POS) begin
            push_coef(p, 16'd0, 1'b1, 1'b1);
            overrun = 1'b1;
          end else begin
            push_coef(p, 16'd0, 1'b0, 1'b0);
            p++;
          end
        end
        if (overrun) begin
          next_pos = 0;
          blk_open = 1'b0;
        end else begin
          push_coef(p, val, p == jcbb_pkg::LAST_POS, 1'b0);
          p++;
          if (p >= jcbb_pkg::BLOCK_SIZE) begin
            next_pos = 0;
            blk_open = 1'b0;
          end else begin
            next_pos = p;
          end
        end
      end
    end
  endtask

  function automatic jcbb_pkg::in_item_t make_symbol(jcbb_pkg::cmd_e cmd, logic [1:0] comp,
                                                     logic [7:0] sym, logic [15:0] extra);
    jcbb_pkg::in_item_t it;
    it.command    = cmd;
    it.component  = comp;
    it.symbol     = sym;
    it.extra_bits = extra;
    return it;
  endfunction

  task automatic send_symbol(input jcbb_pkg::in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sym_cnt++;
    predict_coefs(it);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_dc_values();
    // class zero
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd0, 8'd0, 16'hFFFF));
    // mid-block DC, max class 11
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd1, 8'd11, 16'h07FF));
    // negative, high bits ignored
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd2, 8'd11, 16'hF800));
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd3, 8'd16, 16'hFFFF));
    // class clamps to 16
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd3, 8'd255, 16'h0000));
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd3, 8'd17, 16'h8000));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_EOB, 16'h0000));
    wait_drained();
  endtask

  task automatic test_ac_values();
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd1, 8'd1, 16'h0001));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h01, 16'h0001));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h01, 16'hFFFE));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd2, 8'h0F, 16'hFFFF));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd3, 8'h2F, 16'h0000));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_ZRL, 16'h1234));
    // zero size, nonzero run
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h30, 16'hFFFF));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h1A, 16'hA5A5));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_EOB, 16'hFFFF));
    wait_drained();
  endtask

  task automatic test_block_edges();
    // no open block: dropped
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h11, 16'h0003));
    // run overrun: 3 ZRL reach 49, then a run of 15 hits the end
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd0, 8'd4, 16'h0005));
    repeat (3) send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_ZRL, 16'h0000));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'hF5, 16'h001F));
    // a value lands on the last position and closes the block
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd2, 8'd2, 16'h0001));
    repeat (3) send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_ZRL, 16'h0000));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'hD3, 16'h0006));
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, 8'h02, 16'h0001));
    // block already closed
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_EOB, 16'h0000));
    wait_drained();
  endtask

  // hold the output for a long stretch while the input keeps offering beats
  task automatic test_backpressure();
    int k;
    hold_left = 400;
    send_symbol(make_symbol(jcbb_pkg::CMD_DC, 2'd1, 8'd5, 16'h0011));
    for (k = 0; k < 30; k++) begin
      send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'($urandom),
                              8'h01 | 8'($urandom_range(0, 2) << 4), 16'($urandom)));
    end
    send_symbol(make_symbol(jcbb_pkg::CMD_AC, 2'd0, SYM_EOB, 16'h0000));
    wait_drained();
  endtask

  task automatic test_random_stream(input int n_items);
    int                 cnt;
    int unsigned        pick;
    logic [IN_W-1:0]    raw;
    jcbb_pkg::in_item_t it;
    cnt = 0;
    while (cnt < n_items) begin
      pick = $urandom_range(0, 99);
      raw  = IN_W'($urandom);
      it   = jcbb_pkg::in_item_t'(raw);
      if (pick < 10) begin
        // noise: any field values at all
      end else if (!blk_open) begin
        it.command = jcbb_pkg::CMD_DC;
        if (pick >= 20) it.symbol = 8'($urandom_range(0, 11));
      end else begin
        it.command = jcbb_pkg::CMD_AC;
        if (pick < 16) begin
          it.symbol = SYM_EOB;
        end else if (pick < 24) begin
          it.symbol = SYM_ZRL;
        end else if (pick < 80) begin
          it.symbol = {4'($urandom_range(0, 3)), 4'($urandom_range(1, 11))};
        end
      end
      if (!(it.command == jcbb_pkg::CMD_AC && !blk_open)) cnt++;
      send_symbol(it);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    tx_idle_pct = 37;
    rx_idle_pct = 78;
    hold_left   = 0;
    fail_cnt    = 0;
    sym_cnt     = 0;
    coef_cnt    = 0;
    blk_cnt     = 0;
    next_pos    = 0;
    blk_open    = 1'b0;
    foreach (dc_pred[c]) dc_pred[c] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_dc_values();
    test_ac_values();
    test_block_edges();
    test_random_stream(85);

    tx_idle_pct = 78;
    rx_idle_pct = 37;
    test_random_stream(85);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_stream(80);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d symbol beats and %0d coefficient beats (%0d completed blocks),",
             sym_cnt, coef_cnt, blk_cnt);
    $display("with idle gaps on both channels and one long output hold.");
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
